>>> design/quaternion_to_euler_angles_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle converter
// Each macro checks a property at the rising edge of clk_i outside reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that prop holds at every edge
`define QTE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("qte assertion failed");
// Check that cons holds in the cycle after ante
`define QTE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qte assertion failed");
`else
`define QTE_ASSERT(name, prop)
`define QTE_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Types, widths and angle table shared by the converter cells.
// ----------------------------------------------------------------------------
package qte_pkg;

  // Rotation steps of each CORDIC lane
  localparam int CORDIC_STEPS = 16;
  // Result bits of the integer square root (root of a value up to 2^56)
  localparam int SQRT_STEPS   = 29;
  localparam int SW           = 34;  // Q28 sums
  localparam int CW           = 38;  // CORDIC x and y
  localparam int AW           = 33;  // angle accumulator, 1/65536 cdeg
  localparam int RW           = 57;  // square root remainder and root

  localparam logic signed [AW-1:0] HALF_TURN_Z = 33'sd1179648000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 zero;
  } lane_t;

  // Operands riding along the square root chain
  typedef struct packed {
    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] cr;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] cy;
    logic signed [SW-1:0] sp;
    logic                 clamp;
  } sq_side_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] root;
  } sq_work_t;

  // Data held by one CORDIC cell: roll, pitch and yaw lanes
  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
    logic  clamp;
    logic  sp_neg;
  } cd_work_t;

  // atan(2^-n) in 1/65536 centidegree
  function automatic logic signed [AW-1:0] atan_ent(input logic [4:0] n);
    logic signed [AW-1:0] v;
    case (n)
      5'd0:  v = 33'sd294912000;
      5'd1:  v = 33'sd174096719;
      5'd2:  v = 33'sd91987925;
      5'd3:  v = 33'sd46694507;
      5'd4:  v = 33'sd23437865;
      5'd5:  v = 33'sd11730358;
      5'd6:  v = 33'sd5866610;
      5'd7:  v = 33'sd2933484;
      5'd8:  v = 33'sd1466764;
      5'd9:  v = 33'sd733385;
      5'd10: v = 33'sd366693;
      5'd11: v = 33'sd183346;
      5'd12: v = 33'sd91673;
      5'd13: v = 33'sd45837;
      5'd14: v = 33'sd22918;
      5'd15: v = 33'sd11459;
      5'd16: v = 33'sd5730;
      5'd17: v = 33'sd2865;
      5'd18: v = 33'sd1432;
      5'd19: v = 33'sd716;
      5'd20: v = 33'sd358;
      5'd21: v = 33'sd179;
      5'd22: v = 33'sd90;
      5'd23: v = 33'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One vectoring rotation of a lane
  function automatic lane_t rotate(input lane_t a, input logic [4:0] n);
    lane_t o;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = a.x >>> n;
    ys = a.y >>> n;
    o = a;
    if (a.y < 0) begin
      o.x = a.x - ys;
      o.y = a.y + xs;
      o.z = a.z - atan_ent(n);
    end else begin
      o.x = a.x + ys;
      o.y = a.y - xs;
      o.z = a.z + atan_ent(n);
    end
    return o;
  endfunction

endpackage

>>> design/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Z-Y-X Euler angles from a Q1.14 quaternion through a square root chain
// and a chain of CORDIC cells.
// ----------------------------------------------------------------------------
// channel | signals                               | direction
// in      | in_valid_i, in_ready_o, quat_*_i      | to block
// out     | out_valid_o, out_ready_i, *_cdeg_o    | from block
// cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i  | to block
//
// One quaternion per cycle unless a result waits in the output register;
// data runs through the front, square root, fold, CORDIC and output stages.
// Reset clears every valid bit, the output valid among them, and yaw_negate.
// While a result waits in the output register the whole chain holds.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_top_defines.svh"

module quaternion_to_euler_angles_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_real_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_cdeg_o,
  output logic signed [14:0] pitch_cdeg_o,
  output logic signed [15:0] yaw_cdeg_o,
  output logic               pitch_clamped_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  localparam int SW = qte_pkg::SW;
  localparam int CW = qte_pkg::CW;
  localparam int AW = qte_pkg::AW;
  localparam int RW = qte_pkg::RW;
  localparam int NS = qte_pkg::SQRT_STEPS;
  localparam int NC = qte_pkg::CORDIC_STEPS;

  logic en;
  logic yaw_neg_q;

  // ---- stage 1: products
  logic               s1_vld_q;
  logic signed [31:0] p_ri_q, p_jk_q, p_ii_q, p_jj_q, p_rk_q, p_ij_q, p_kk_q;
  logic signed [31:0] p_rj_q, p_ki_q;

  // ---- stage 2: sums
  logic               s2_vld_q;
  qte_pkg::sq_side_t  s2_side_q;
  logic [27:0]        s2_mag_q;
  logic signed [SW-1:0] sp_d;
  logic               clamp_d;

  // ---- stage 3: square
  logic               s3_vld_q;
  qte_pkg::sq_side_t  s3_side_q;
  logic [55:0]        s3_sq_q;

  // ---- square root chain
  logic              sq_vld  [NS+1];
  qte_pkg::sq_work_t sq_work [NS+1];
  qte_pkg::sq_side_t sq_side [NS+1];

  // ---- CORDIC chain
  logic              cd_vld  [NC+1];
  qte_pkg::cd_work_t cd_work [NC+1];
  qte_pkg::cd_work_t cd_init_d;

  // ---- output
  logic               out_vld_q;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic               clamp_q;
  logic signed [15:0] roll_d, yaw_d;
  logic signed [14:0] pitch_d;
  logic signed [AW-1:0] z_yaw;

  // Hold every stage while a result waits
  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Latch yaw_negate on a config transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_neg_q <= 1'b0;
    end else if (cfg_valid_i) begin
      yaw_neg_q <= cfg_data_i;
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Form the pitch term and its clamp
  always_comb begin
    sp_d    = SW'(p_rj_q) - SW'(p_ki_q);
    sp_d    = sp_d <<< 1;
    clamp_d = (sp_d >= (SW'(1) <<< 28)) || (sp_d <= -(SW'(1) <<< 28));
  end

  // Front stages: products, sums, square of the pitch term
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ri_q <= quat_real_i * quat_x_i;
      p_jk_q <= quat_y_i * quat_z_i;
      p_ii_q <= quat_x_i * quat_x_i;
      p_jj_q <= quat_y_i * quat_y_i;
      p_rk_q <= quat_real_i * quat_z_i;
      p_ij_q <= quat_x_i * quat_y_i;
      p_kk_q <= quat_z_i * quat_z_i;
      p_rj_q <= quat_real_i * quat_y_i;
      p_ki_q <= quat_z_i * quat_x_i;

      s2_side_q.sr    <= (SW'(p_ri_q) + SW'(p_jk_q)) <<< 1;
      s2_side_q.cr    <= (SW'(1) <<< 28) - ((SW'(p_ii_q) + SW'(p_jj_q)) <<< 1);
      s2_side_q.sy    <= (SW'(p_rk_q) + SW'(p_ij_q)) <<< 1;
      s2_side_q.cy    <= (SW'(1) <<< 28) - ((SW'(p_jj_q) + SW'(p_kk_q)) <<< 1);
      s2_side_q.sp    <= sp_d;
      s2_side_q.clamp <= clamp_d;
      if (clamp_d) begin
        s2_mag_q <= '0;
      end else if (sp_d < 0) begin
        s2_mag_q <= 28'(-sp_d);
      end else begin
        s2_mag_q <= 28'(sp_d);
      end

      s3_side_q <= s2_side_q;
      s3_sq_q   <= s2_mag_q * s2_mag_q;
    end
  end

  // Feed the square root chain with 1 - s*s in Q56
  assign sq_vld[0]       = s3_vld_q;
  assign sq_side[0]      = s3_side_q;
  assign sq_work[0].rem  = (RW'(1) << 56) - RW'(s3_sq_q);
  assign sq_work[0].root = '0;

  for (genvar n = 0; n < NS; n++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (5'(NS - 1 - n)),
      .vld_i  (sq_vld[n]),
      .work_i (sq_work[n]),
      .side_i (sq_side[n]),
      .vld_o  (sq_vld[n+1]),
      .work_o (sq_work[n+1]),
      .side_o (sq_side[n+1])
    );
  end

  // Fold each operand pair into the right half plane
  function automatic qte_pkg::lane_t lane_init(input logic signed [CW-1:0] y,
                                               input logic signed [CW-1:0] x);
    qte_pkg::lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x    = x;
    l.y    = y;
    l.z    = '0;
    if (x < 0) begin
      l.z = (y >= 0) ? qte_pkg::HALF_TURN_Z : -qte_pkg::HALF_TURN_Z;
      l.x = -x;
      l.y = -y;
    end
    return l;
  endfunction

  always_comb begin
    cd_init_d.roll   = lane_init(CW'(sq_side[NS].sr), CW'(sq_side[NS].cr));
    cd_init_d.pitch  = lane_init(CW'(sq_side[NS].sp),
                                 CW'($signed({1'b0, sq_work[NS].root[28:0]})));
    cd_init_d.yaw    = lane_init(CW'(sq_side[NS].sy), CW'(sq_side[NS].cy));
    cd_init_d.clamp  = sq_side[NS].clamp;
    cd_init_d.sp_neg = sq_side[NS].sp < 0;
  end

  // Register the folded operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_vld[0] <= 1'b0;
    end else if (en) begin
      cd_vld[0] <= sq_vld[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_work[0] <= cd_init_d;
    end
  end

  for (genvar n = 0; n < NC; n++) begin : g_cordic
    qte_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (5'(n)),
      .vld_i  (cd_vld[n]),
      .work_i (cd_work[n]),
      .vld_o  (cd_vld[n+1]),
      .work_o (cd_work[n+1])
    );
  end

  // Round an angle to centidegrees
  function automatic logic signed [17:0] round_cdeg(input logic signed [AW-1:0] z,
                                                    input logic zero);
    logic signed [AW:0] t;
    t = (AW+1)'(z) + (AW+1)'(32768);
    if (zero) begin
      t = '0;
    end
    return 18'(t >>> 16);
  endfunction

  // Fold into [-18000, 18000)
  function automatic logic signed [15:0] fold(input logic signed [17:0] c);
    logic signed [17:0] f;
    f = c;
    if (c >= 18'sd18000) begin
      f = c - 18'sd36000;
    end else if (c < -18'sd18000) begin
      f = c + 18'sd36000;
    end
    return 16'(f);
  endfunction

  // Finish the three angles
  always_comb begin
    z_yaw  = yaw_neg_q ? -cd_work[NC].yaw.z : cd_work[NC].yaw.z;
    roll_d = fold(round_cdeg(cd_work[NC].roll.z, cd_work[NC].roll.zero));
    yaw_d  = fold(round_cdeg(z_yaw, cd_work[NC].yaw.zero));
    if (cd_work[NC].clamp) begin
      pitch_d = cd_work[NC].sp_neg ? -15'sd9000 : 15'sd9000;
    end else begin
      pitch_d = 15'(round_cdeg(cd_work[NC].pitch.z, cd_work[NC].pitch.zero));
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= cd_vld[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
      clamp_q <= cd_work[NC].clamp;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign roll_cdeg_o     = roll_q;
  assign pitch_cdeg_o    = pitch_q;
  assign yaw_cdeg_o      = yaw_q;
  assign pitch_clamped_o = clamp_q;

  // Checks
  `QTE_ASSERT(a_stall_only_on_full, !in_ready_o |-> out_valid_o)
  `QTE_ASSERT(a_clamp_pitch, out_valid_o && pitch_clamped_o |->
    (pitch_cdeg_o == 15'sd9000 || pitch_cdeg_o == -15'sd9000))
  `QTE_ASSERT(a_roll_range, out_valid_o |->
    (roll_cdeg_o >= -16'sd18000 && roll_cdeg_o <= 16'sd17999))
  `QTE_ASSERT_NEXT(a_hold_on_stall, out_valid_o && !out_ready_i,
    out_valid_o && $stable(yaw_cdeg_o))

endmodule

>>> design/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One bit of the restoring integer square root; passes side operands on.
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [4:0]          step_i,
  input  logic                vld_i,
  input  qte_pkg::sq_work_t   work_i,
  input  qte_pkg::sq_side_t   side_i,
  output logic                vld_o,
  output qte_pkg::sq_work_t   work_o,
  output qte_pkg::sq_side_t   side_o
);

  logic [qte_pkg::RW-1:0] bit_w;
  logic [qte_pkg::RW-1:0] trial;
  qte_pkg::sq_work_t      work_d;
  logic                   vld_q;
  qte_pkg::sq_work_t      work_q;
  qte_pkg::sq_side_t      side_q;

  // Try this bit of the root
  always_comb begin
    bit_w  = qte_pkg::RW'(1) << {step_i, 1'b0};
    trial  = work_i.root + bit_w;
    work_d = work_i;
    if (work_i.rem >= trial) begin
      work_d.rem  = work_i.rem - trial;
      work_d.root = (work_i.root >> 1) + bit_w;
    end else begin
      work_d.root = work_i.root >> 1;
    end
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Advance data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign work_o = work_q;
  assign side_o = side_q;

endmodule

>>> design/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One CORDIC rotation applied to the roll, pitch and yaw lanes.
// ----------------------------------------------------------------------------
module qte_cordic_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [4:0]        step_i,
  input  logic              vld_i,
  input  qte_pkg::cd_work_t work_i,
  output logic              vld_o,
  output qte_pkg::cd_work_t work_o
);

  qte_pkg::cd_work_t work_d;
  logic              vld_q;
  qte_pkg::cd_work_t work_q;

  // Rotate each lane by this step's angle
  always_comb begin
    work_d       = work_i;
    work_d.roll  = qte_pkg::rotate(work_i.roll, step_i);
    work_d.pitch = qte_pkg::rotate(work_i.pitch, step_i);
    work_d.yaw   = qte_pkg::rotate(work_i.yaw, step_i);
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Advance data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign vld_o  = vld_q;
  assign work_o = work_q;

endmodule
